@@ sv/srx_pkg.sv @@
`timescale 1ns / 1ps

package srx_pkg;

    // One received or emitted byte.
    typedef logic [7:0] t_byte;

    // Frame delimiters and the checksum modulus.
    localparam t_byte SYNC_FIRST  = 8'hAA;
    localparam t_byte SYNC_SECOND = 8'h55;
    localparam t_byte SUM_MODULUS = 8'hFF;

    // Input operation codes.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

endpackage

@@ sv/sync_framed_packet_receiver_top.sv @@
`timescale 1ns / 1ps
// Input words are taken while no packet is being emitted.
// A good checksum word starts emission: each payload word is fetched from
// the registered payload memory, then output; an empty packet skips the fetch
// and is shown as a single word with a zero byte. An output stall holds the word.
// Synchronous active-low reset returns the hunter to first-sync search.
module sync_framed_packet_receiver_top
    import srx_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_header,
    output logic [4:0] o_payload_length,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    localparam int LW = (MAX_PAYLOAD > 2) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [2:0] {
        FR_SYNC1  = 3'd0,
        FR_SYNC2  = 3'd1,
        FR_HEADER = 3'd2,
        FR_LENGTH = 3'd3,
        FR_DATA   = 3'd4,
        FR_CHECK  = 3'd5
    } t_frame;

    typedef enum logic [1:0] {
        SQ_ACCEPT,
        SQ_FETCH,
        SQ_SHOW
    } t_seq;

    t_frame        r_frame, n_frame;
    t_seq          r_seq, n_seq;
    t_byte         r_header, n_header;
    t_byte         r_sum, n_sum;
    logic [LW-1:0] r_length, n_length;
    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_empty, n_empty;

    logic          w_accept;
    logic          w_out_take;
    t_byte         w_sum_next;
    t_byte         w_rd_data;
    logic          w_wr_en;
    logic          w_fill_done;
    logic          w_idx_last;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = o_out_valid && !i_out_stall;

    // Shared accumulator step: the length byte and every payload byte pass here.
    srx_sum_unit u_sum (
        .i_sum  (r_sum),
        .i_byte (i_rx_byte),
        .o_sum  (w_sum_next)
    );

    // Payload is written while filling and read back one word per fetch.
    assign w_wr_en = w_accept && (i_op == OP_BYTE) && (r_frame == FR_DATA);

    srx_payload_mem #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (LW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (r_seq == SQ_FETCH),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_fill_done = ({1'b0, r_fill} + 1'b1) >= {1'b0, r_length};
    assign w_idx_last  = r_empty || (({1'b0, r_idx} + 1'b1) == {1'b0, r_length});

    // Frame hunter and emission sequencer.
    always_comb begin
        n_frame  = r_frame;
        n_seq    = r_seq;
        n_header = r_header;
        n_sum    = r_sum;
        n_length = r_length;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_empty  = r_empty;

        case (r_seq)
            SQ_ACCEPT: begin
                if (w_accept) begin
                    if (i_op == OP_TIMEOUT) begin
                        n_frame = FR_SYNC1;
                    end else begin
                        case (r_frame)
                            FR_SYNC2: begin
                                n_frame = (i_rx_byte == SYNC_SECOND) ? FR_HEADER : FR_SYNC1;
                            end
                            FR_HEADER: begin
                                n_header = i_rx_byte;
                                n_sum    = i_rx_byte;
                                n_frame  = FR_LENGTH;
                            end
                            FR_LENGTH: begin
                                if ({1'b0, i_rx_byte} < 9'(MAX_PAYLOAD)) begin
                                    n_length = i_rx_byte[LW-1:0];
                                    n_sum    = w_sum_next;
                                    n_fill   = '0;
                                    n_frame  = (i_rx_byte != '0) ? FR_DATA : FR_CHECK;
                                end else begin
                                    n_frame = FR_SYNC1;
                                end
                            end
                            FR_DATA: begin
                                n_sum  = w_sum_next;
                                n_fill = r_fill + 1'b1;
                                if (w_fill_done) begin
                                    n_frame = FR_CHECK;
                                end
                            end
                            FR_CHECK: begin
                                n_frame = FR_SYNC1;
                                if (r_sum == i_rx_byte) begin
                                    n_idx   = '0;
                                    n_empty = (r_length == '0);
                                    n_seq   = (r_length == '0) ? SQ_SHOW : SQ_FETCH;
                                end
                            end
                            default: begin
                                n_frame = (i_rx_byte == SYNC_FIRST) ? FR_SYNC2 : FR_SYNC1;
                            end
                        endcase
                    end
                end
            end
            SQ_FETCH: begin
                n_seq = SQ_SHOW;
            end
            SQ_SHOW: begin
                if (w_out_take) begin
                    if (w_idx_last) begin
                        n_seq = SQ_ACCEPT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_seq = SQ_FETCH;
                    end
                end
            end
            default: begin
                n_seq = SQ_ACCEPT;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame  <= FR_SYNC1;
            r_seq    <= SQ_ACCEPT;
            r_header <= '0;
            r_sum    <= '0;
            r_length <= '0;
            r_fill   <= '0;
            r_idx    <= '0;
            r_empty  <= 1'b0;
        end else begin
            r_frame  <= n_frame;
            r_seq    <= n_seq;
            r_header <= n_header;
            r_sum    <= n_sum;
            r_length <= n_length;
            r_fill   <= n_fill;
            r_idx    <= n_idx;
            r_empty  <= n_empty;
        end
    end

    // Port drive: input is held off during reset and while a packet drains.
    assign o_in_stall       = !i_rst_n || (r_seq != SQ_ACCEPT);
    assign o_out_valid      = (r_seq == SQ_SHOW);
    assign o_header         = r_header;
    assign o_payload_length = 5'(r_length);
    assign o_byte_index     = 5'(r_idx);
    assign o_payload_byte   = r_empty ? 8'h00 : w_rd_data;
    assign o_last           = w_idx_last;

endmodule

@@ sv/srx_sum_unit.sv @@
`timescale 1ns / 1ps

module srx_sum_unit
    import srx_pkg::*;
(
    input  t_byte i_sum,
    input  t_byte i_byte,
    output t_byte o_sum
);

    logic [8:0] w_total;
    logic [8:0] w_reduced;

    // Add, then take one modulus off; the sum is at most twice the modulus.
    assign w_total   = {1'b0, i_sum} + {1'b0, i_byte};
    assign w_reduced = (w_total >= {1'b0, SUM_MODULUS}) ? (w_total - {1'b0, SUM_MODULUS})
                                                        : w_total;

    // A result equal to the modulus is congruent to zero.
    assign o_sum = (w_reduced[7:0] == SUM_MODULUS) ? '0 : w_reduced[7:0];

endmodule

@@ sv/srx_payload_mem.sv @@
`timescale 1ns / 1ps

module srx_payload_mem
    import srx_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_byte         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_byte         o_rd_data
);

    t_byte r_mem [DEPTH];
    t_byte r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/srx_port_checker.sv @@
`timescale 1ns / 1ps

module srx_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_op,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [4:0] o_byte_index,
    input logic [7:0] o_payload_byte,
    input logic       o_last
);

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_byte_index) && $stable(o_payload_byte)
             && $stable(o_last)))
        else $error("stalled output word changed");

    // No input word is taken while a packet is being emitted.
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while output valid");

    // A taken word that is not the last keeps the input closed.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> o_in_stall)
        else $error("packet run ended early");

    // After the last word the block is open again and quiet.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> (!o_in_stall && !o_out_valid))
        else $error("block not ready after last word");

    // A timeout word never produces output.
    a_timeout_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_op) |=> !o_out_valid)
        else $error("output after timeout");

endmodule

bind sync_framed_packet_receiver_top srx_port_checker u_srx_port_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_op           (i_op),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_byte_index   (o_byte_index),
    .o_payload_byte (o_payload_byte),
    .o_last         (o_last)
);
